// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the bitmap block allocator
// Request and result transaction types, codes and fixed widths.
// ----------------------------------------------------------------------------
package bba_pkg;

  // default sizes
  localparam int unsigned MAP_BITS_DEF       = 4096;
  localparam int unsigned SLOTS_PER_FILE_DEF = 16;

  // bitmap word width and fixed index widths
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = 5;   // log2 of WORD_W
  localparam int unsigned IDX_W  = 16;  // block index, MAP_BITS up to 65536
  localparam int unsigned LIM_W  = 17;  // effective count, up to 65536

  // request kinds
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_NOSPACE = 2'd2,
    STATUS_BADBLK  = 2'd3
  } status_e;

  // configuration register indexes
  typedef enum logic {
    CFG_REGION_START     = 1'b0,
    CFG_DATA_BLOCK_COUNT = 1'b1
  } cfg_idx_e;

  // command kinds between front and back
  typedef enum logic [1:0] {
    CMD_REPLY = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_SET   = 2'd2,
    CMD_SPARE = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  block_count;
    logic [4:0]  used_slots;
    logic [31:0] block_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] block_out;
    logic        block_valid;
    logic        last;
  } out_item_t;

  // classified request queued for the back end
  typedef struct packed {
    cmd_kind_e        kind;
    status_e          status;
    logic [4:0]       cnt;
    logic [IDX_W-1:0] idx;
    logic             set_val;
  } cmd_t;

endpackage

// ===== rtl/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator: first-fit block allocator over a used/free bitmap
//
//   channel  direction  handshake           payload
//   in       input      in_valid / stall    bba_pkg::in_item_t
//   out      output     out_valid / stall   bba_pkg::out_item_t
//   cfg      input      cfg_valid / ready   index + 32-bit data
//
// After reset the bitmap is cleared one 32-bit word per cycle; requests queue
// up but are not executed meanwhile.
// Free and mark-used read the bitmap word and write it back; allocate reads
// and scans one bitmap word at a time, records each free block found, then
// updates each found block with a read and a write. The word-by-word scan
// over the bitmap memory sets the allocate time. Two queued requests decouple
// intake from execution; a stalled output holds the back end, not the intake.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
  parameter int unsigned MAP_BITS       = bba_pkg::MAP_BITS_DEF,
  parameter int unsigned SLOTS_PER_FILE = bba_pkg::SLOTS_PER_FILE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bba_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bba_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import bba_pkg::*;

  logic [31:0]      region_start_q;
  logic [12:0]      data_block_count_q;
  logic [LIM_W-1:0] lim;
  logic             cmd_valid, cmd_pop;
  cmd_t             cmd;

  assign cfg_ready_o = 1'b1;

  // effective block count, clipped to the bitmap size
  assign lim = (32'(data_block_count_q) > MAP_BITS) ? LIM_W'(MAP_BITS)
                                                    : LIM_W'(data_block_count_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q     <= '0;
      data_block_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_REGION_START:     region_start_q     <= cfg_data_i;
        CFG_DATA_BLOCK_COUNT: data_block_count_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  bba_front #(
    .SLOTS_PER_FILE(SLOTS_PER_FILE)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .region_start_i(region_start_q),
    .lim_i         (lim),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  bba_back #(
    .MAP_BITS      (MAP_BITS),
    .SLOTS_PER_FILE(SLOTS_PER_FILE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .region_start_i(region_start_q),
    .lim_i         (lim),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

// ===== rtl/bba_front.sv =====
// ----------------------------------------------------------------------------
// bba_front: request intake and classification
// Checks limits and ranges and queues a command for the back end.
// ----------------------------------------------------------------------------
module bba_front #(
  parameter int unsigned SLOTS_PER_FILE = bba_pkg::SLOTS_PER_FILE_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  bba_pkg::in_item_t        in_data_i,
  input  logic [31:0]              region_start_i,
  input  logic [bba_pkg::LIM_W-1:0] lim_i,
  output logic                     cmd_valid_o,
  output bba_pkg::cmd_t            cmd_o,
  input  logic                     cmd_pop_i
);
  import bba_pkg::*;

  cmd_t        cmd_new;
  logic [31:0] diff;
  logic        in_range;
  logic [5:0]  slot_sum;
  logic        push;

  // two-entry command queue
  cmd_t       q_mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  // classification
  always_comb begin
    diff     = in_data_i.block_number - region_start_i;
    in_range = (in_data_i.block_number >= region_start_i) && (diff < 32'(lim_i));
    slot_sum = 6'(in_data_i.used_slots) + 6'(in_data_i.block_count);
    cmd_new         = '0;
    cmd_new.kind    = CMD_REPLY;
    cmd_new.status  = STATUS_OK;
    cmd_new.cnt     = in_data_i.block_count;
    cmd_new.idx     = diff[IDX_W-1:0];
    unique case (op_e'(in_data_i.op))
      OP_ALLOC: begin
        if (in_data_i.block_count == 5'd0) begin
          cmd_new.kind = CMD_REPLY;
        end else if (32'(slot_sum) > SLOTS_PER_FILE) begin
          cmd_new.status = STATUS_NOSPACE;
        end else begin
          cmd_new.kind = CMD_ALLOC;
        end
      end
      OP_FREE: begin
        if (in_range) cmd_new.kind = CMD_SET;
        else cmd_new.status = STATUS_BADBLK;
        cmd_new.set_val = 1'b0;
      end
      OP_MARK: begin
        if (in_range) cmd_new.kind = CMD_SET;
        else cmd_new.status = STATUS_INVALID;
        cmd_new.set_val = 1'b1;
      end
      default: begin
        cmd_new.status = STATUS_INVALID;
      end
    endcase
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !cmd_pop_i) count_d = count_q + 2'd1;
    else if (!push && cmd_pop_i) count_d = count_q - 2'd1;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= !rd_ptr_q;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= cmd_new;
  end

endmodule

// ===== rtl/bba_back.sv =====
// ----------------------------------------------------------------------------
// bba_back: bitmap store and request execution
// Clears the bitmap after reset, scans it for free bits, applies updates
// and drives the result register.
// ----------------------------------------------------------------------------
module bba_back #(
  parameter int unsigned MAP_BITS       = bba_pkg::MAP_BITS_DEF,
  parameter int unsigned SLOTS_PER_FILE = bba_pkg::SLOTS_PER_FILE_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  input  bba_pkg::cmd_t             cmd_i,
  output logic                      cmd_pop_o,
  input  logic [31:0]               region_start_i,
  input  logic [bba_pkg::LIM_W-1:0] lim_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output bba_pkg::out_item_t        out_data_o
);
  import bba_pkg::*;

  localparam int unsigned NWORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned NW     = $clog2(SLOTS_PER_FILE + 1);
  localparam int unsigned FW     = (SLOTS_PER_FILE > 1) ? $clog2(SLOTS_PER_FILE) : 1;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_RD, S_LOAD, S_SCAN, S_MRD, S_MWR, S_REPLY
  } back_state_e;

  back_state_e state_q, state_d;

  logic [WORD_W-1:0] mem [NWORDS];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_re, mem_we;
  logic [AW-1:0]     mem_raddr, mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  logic [AW-1:0]     clr_q, word_q, word_d;
  logic [WORD_W-1:0] wf_q, wf_d;
  logic [NW-1:0]     n_q, n_d, k_q, k_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [IDX_W-1:0]  cur_idx_q, cur_idx_d;
  logic              set_val_q, set_val_d, is_alloc_q, is_alloc_d;
  status_e           status_q, status_d;
  logic [IDX_W-1:0]  found_q [SLOTS_PER_FILE];
  logic              found_we;
  logic [IDX_W-1:0]  found_val;

  logic              out_valid_q;
  out_item_t         out_q, out_d;
  logic              can_emit, emit;

  logic [31:0]       rem, base32, next_base32;
  logic [WORD_W-1:0] lim_mask, low_hot;
  logic [BIT_W-1:0]  low_pos;
  logic [IDX_W-1:0]  sel_idx;
  logic [AW-1:0]     sel_word;
  logic [WORD_W-1:0] sel_bit;
  logic              alloc_done;

  assign can_emit  = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // word base, valid-bit mask of the word and lowest free bit
  always_comb begin
    base32      = 32'(word_q) << BIT_W;
    next_base32 = (32'(word_q) + 32'd1) << BIT_W;
    rem         = 32'(lim_i) - base32;
    if (rem >= 32'(WORD_W)) lim_mask = '1;
    else lim_mask = (WORD_W'(1) << rem[BIT_W-1:0]) - WORD_W'(1);
    low_hot = wf_q & (~wf_q + WORD_W'(1));
    low_pos = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (low_hot[j]) low_pos = BIT_W'(j);
    end
    found_val = IDX_W'(base32) + IDX_W'(low_pos);
    sel_idx   = is_alloc_q ? found_q[k_q[FW-1:0]] : cur_idx_q;
    sel_word  = AW'(32'(sel_idx) >> BIT_W);
    sel_bit   = WORD_W'(1) << sel_idx[BIT_W-1:0];
    alloc_done = (32'(k_q) + 32'd1) == 32'(cnt_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:   if (clr_q == AW'(NWORDS - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_ALLOC: state_d = (lim_i == '0) ? S_REPLY : S_RD;
            CMD_SET:   state_d = S_MRD;
            default:   state_d = S_REPLY;
          endcase
        end
      end
      S_RD:   state_d = S_LOAD;
      S_LOAD: state_d = S_SCAN;
      S_SCAN: begin
        if (wf_q == '0) begin
          state_d = (next_base32 >= 32'(lim_i)) ? S_REPLY : S_RD;
        end else if ((32'(n_q) + 32'd1) == 32'(cnt_q)) begin
          state_d = S_MRD;
        end
      end
      S_MRD: state_d = S_MWR;
      S_MWR: begin
        if (can_emit) state_d = (is_alloc_q && !alloc_done) ? S_MRD : S_IDLE;
      end
      S_REPLY: if (can_emit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_pop_o  = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_raddr  = sel_word;
    mem_waddr  = sel_word;
    mem_wdata  = set_val_q ? (rdata_q | sel_bit) : (rdata_q & ~sel_bit);
    word_d     = word_q;
    wf_d       = wf_q;
    n_d        = n_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    cur_idx_d  = cur_idx_q;
    set_val_d  = set_val_q;
    is_alloc_d = is_alloc_q;
    status_d   = status_q;
    found_we   = 1'b0;
    emit       = 1'b0;
    out_d      = '0;
    out_d.last = 1'b1;
    unique case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o  = 1'b1;
          cnt_d      = cmd_i.cnt;
          cur_idx_d  = cmd_i.idx;
          set_val_d  = cmd_i.set_val || (cmd_i.kind == CMD_ALLOC);
          is_alloc_d = (cmd_i.kind == CMD_ALLOC);
          status_d   = (cmd_i.kind == CMD_ALLOC) ? STATUS_NOSPACE : cmd_i.status;
          word_d     = '0;
          n_d        = '0;
          k_d        = '0;
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        mem_raddr = word_q;
      end
      S_LOAD: wf_d = ~rdata_q & lim_mask;
      S_SCAN: begin
        if (wf_q == '0) begin
          word_d = word_q + AW'(1);
        end else begin
          found_we = 1'b1;
          wf_d     = wf_q & ~low_hot;
          n_d      = n_q + NW'(1);
        end
      end
      S_MRD: mem_re = 1'b1;
      S_MWR: begin
        if (can_emit) begin
          mem_we = 1'b1;
          emit   = 1'b1;
          out_d.status = STATUS_OK;
          if (is_alloc_q) begin
            out_d.block_out   = region_start_i + 32'(sel_idx);
            out_d.block_valid = 1'b1;
            out_d.last        = alloc_done;
            k_d               = k_q + NW'(1);
          end
        end
      end
      S_REPLY: begin
        emit         = can_emit;
        out_d.status = status_q;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + AW'(1);
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    wf_q       <= wf_d;
    n_q        <= n_d;
    k_q        <= k_d;
    cnt_q      <= cnt_d;
    cur_idx_q  <= cur_idx_d;
    set_val_q  <= set_val_d;
    is_alloc_q <= is_alloc_d;
    status_q   <= status_d;
    if (found_we) found_q[n_q[FW-1:0]] <= found_val;
    if (emit) out_q <= out_d;
  end

  // bitmap memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

endmodule

// ===== rtl/bba_checker.sv =====
// ----------------------------------------------------------------------------
// bba_checker: port-level checks of the bitmap block allocator
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input bba_pkg::out_item_t out_data_o
);
  import bba_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // an allocated block always carries an ok status
  a_blk_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.block_valid |-> out_data_o.status == STATUS_OK)
    else $error("allocated block with error status");

  // a result without a block ends its request and carries zero
  a_noblk_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.block_valid |->
      out_data_o.last && out_data_o.block_out == 32'd0)
    else $error("blockless result not single and zero");

  // a non-final result is followed only by further blocks of the same request
  a_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=>
      !out_valid_o || out_data_o.block_valid)
    else $error("allocation sequence broken");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
